### rtl/cbpm_pkg.sv
// Shared constants and register codes for the cubic Bezier point mapper.
// No dependencies; the mapper top level refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cbpm_pkg;

	// Curve resolution: t = step_index / STEPS. STEPS is a power of two.
	localparam int STEPS_LOG2   = 10;
	localparam int STEPS        = 1 << STEPS_LOG2;

	// Screen and user window
	localparam int SCREEN_MAX_X = 639;
	localparam int SCREEN_MAX_Y = 479;
	localparam int USER_SPAN    = 6;

	// Field widths
	localparam int IDX_W        = STEPS_LOG2 + 1;
	localparam int COORD_W      = 11;
	localparam int PIX_W        = 19;
	localparam int SCALE_W      = 12;
	localparam int SPAN_W       = 11;
	localparam int CFG_IDX_W    = 4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P0_X = 4'd0,
		REG_P1_X = 4'd1,
		REG_P2_X = 4'd2,
		REG_P3_X = 4'd3,
		REG_P0_Y = 4'd4,
		REG_P1_Y = 4'd5,
		REG_P2_Y = 4'd6,
		REG_P3_Y = 4'd7
	} cfg_reg_t;

endpackage

`default_nettype wire

### rtl/cubic_bezier_point_mapper_unit.sv
// Cubic Bezier point mapper top level: nine-stage pipeline from step index to pixel.
// Depends on cbpm_pkg for constants and register codes.
//
// Usage:
//   Write the four control points (x at indexes 0..3, y at 4..7) through
//   cfg_we / cfg_index / cfg_data while no item is in flight. Writes to
//   indexes above 7 are dropped.
//   Items enter on step_valid / step_stall carrying step_index; values
//   above STEPS are clamped to STEPS. Results leave on point_valid /
//   point_stall with pixel_x, pixel_y (y flipped) and on_screen.
//   Throughput is one item per cycle while point_stall is low. The depth
//   is set by the weight multipliers, the control point multipliers, the
//   wide Bernstein sum and the scale and reciprocal multipliers, each in
//   a stage of its own.
//   Each stage holds its item while the stage after it is full and
//   stalled, so bubbles close up under a stall and step_stall rises only
//   when all nine stages are full and point_stall is high.
//   Reset (arst_n low) clears all valid bits and sets every control
//   point to zero.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_point_mapper_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [cbpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cbpm_pkg::COORD_W-1:0]        cfg_data,
	// step items
	input  wire logic                                step_valid,
	output logic                                     step_stall,
	input  wire logic [cbpm_pkg::IDX_W-1:0]          step_index,
	// point items
	output logic                                     point_valid,
	input  wire logic                                point_stall,
	output logic signed [cbpm_pkg::PIX_W-1:0]        pixel_x,
	output logic signed [cbpm_pkg::PIX_W-1:0]        pixel_y,
	output logic                                     on_screen
);

	// Derived widths
	localparam int IDX_W   = cbpm_pkg::IDX_W;
	localparam int COORD_W = cbpm_pkg::COORD_W;
	localparam int PIX_W   = cbpm_pkg::PIX_W;
	localparam int SL      = cbpm_pkg::STEPS_LOG2;
	localparam int U2_W    = 2 * SL + 1;
	localparam int W_W     = 3 * SL + 1;
	localparam int M_W     = U2_W + IDX_W + 2;
	localparam int PROD_W  = W_W + COORD_W;
	localparam int SUM_W   = PROD_W;
	localparam int MAG_W   = SUM_W - 1;
	localparam int SP_W    = MAG_W + cbpm_pkg::SCALE_W;
	localparam int N_W     = SP_W - 3 * SL;
	localparam int RSH     = N_W + cbpm_pkg::SPAN_W;
	localparam int R_W     = RSH + 1;
	localparam int QP_W    = N_W + R_W;
	localparam int Q_W     = N_W;
	localparam int V_W     = Q_W + 2;
	localparam int CUBE_W  = W_W + 2;

	localparam logic [R_W-1:0] RECIP = R_W'(((64'd1 << RSH) + 64'(cbpm_pkg::USER_SPAN)
		- 64'd1) / 64'(cbpm_pkg::USER_SPAN));
	localparam logic signed [V_W-1:0] OUT_MAX = V_W'((1 << (PIX_W - 1)) - 1);
	localparam logic signed [V_W-1:0] OUT_MIN = -V_W'(1 << (PIX_W - 1));
	localparam logic signed [V_W-1:0] MAX_X_V = V_W'(cbpm_pkg::SCREEN_MAX_X);
	localparam logic signed [V_W-1:0] MAX_Y_V = V_W'(cbpm_pkg::SCREEN_MAX_Y);

	// Saturate a coordinate to the pixel range
	function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [V_W-1:0] v);
		logic signed [PIX_W-1:0] r;
		if (v > OUT_MAX) begin
			r = OUT_MAX[PIX_W-1:0];
		end else if (v < OUT_MIN) begin
			r = OUT_MIN[PIX_W-1:0];
		end else begin
			r = v[PIX_W-1:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic signed [COORD_W-1:0] p0_x_q, p1_x_q, p2_x_q, p3_x_q;
	logic signed [COORD_W-1:0] p0_y_q, p1_y_q, p2_y_q, p3_y_q;

	// Write the addressed control point; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_x_q <= '0;
			p1_x_q <= '0;
			p2_x_q <= '0;
			p3_x_q <= '0;
			p0_y_q <= '0;
			p1_y_q <= '0;
			p2_y_q <= '0;
			p3_y_q <= '0;
		end else if (cfg_we) begin
			case (cbpm_pkg::cfg_reg_t'(cfg_index))
				cbpm_pkg::REG_P0_X: p0_x_q <= cfg_data;
				cbpm_pkg::REG_P1_X: p1_x_q <= cfg_data;
				cbpm_pkg::REG_P2_X: p2_x_q <= cfg_data;
				cbpm_pkg::REG_P3_X: p3_x_q <= cfg_data;
				cbpm_pkg::REG_P0_Y: p0_y_q <= cfg_data;
				cbpm_pkg::REG_P1_Y: p1_y_q <= cfg_data;
				cbpm_pkg::REG_P2_Y: p2_y_q <= cfg_data;
				cbpm_pkg::REG_P3_Y: p3_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Pipeline flow control
	// ---------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;

	// A stage takes a new item when it is empty or its item moves on
	assign en_s9 = !vld_s9 || !point_stall;
	assign en_s8 = !vld_s8 || en_s9;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign step_stall  = !en_s1;
	assign point_valid = vld_s9;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= step_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_s9) vld_s9 <= vld_s8;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: clamp the step index and form u = STEPS - i
	// ---------------------------------------------------------------
	logic [IDX_W-1:0] i_s1, u_s1;
	logic [IDX_W-1:0] i_clamp;

	assign i_clamp = (step_index > IDX_W'(cbpm_pkg::STEPS)) ? IDX_W'(cbpm_pkg::STEPS)
		: step_index;

	always_ff @(posedge clk) begin
		if (en_s1 && step_valid) begin
			i_s1 <= i_clamp;
			u_s1 <= IDX_W'(cbpm_pkg::STEPS) - i_clamp;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: squares and cross product
	// ---------------------------------------------------------------
	logic [U2_W-1:0]  u2_s2, i2_s2, ui_s2;
	logic [IDX_W-1:0] i_s2, u_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			u2_s2 <= U2_W'(u_s1 * u_s1);
			i2_s2 <= U2_W'(i_s1 * i_s1);
			ui_s2 <= U2_W'(u_s1 * i_s1);
			i_s2  <= i_s1;
			u_s2  <= u_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: Bernstein weights scaled by STEPS^3
	// ---------------------------------------------------------------
	logic [W_W-1:0] w0_s3, w1_s3, w2_s3, w3_s3;
	logic [M_W-1:0] m1, m2;

	assign m1 = M_W'(ui_s2) * M_W'(u_s2);
	assign m2 = M_W'(ui_s2) * M_W'(i_s2);

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			w0_s3 <= W_W'(u2_s2 * u_s2);
			w1_s3 <= W_W'(m1 + (m1 << 1));
			w2_s3 <= W_W'(m2 + (m2 << 1));
			w3_s3 <= W_W'(i2_s2 * i_s2);
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: weight each control point
	// ---------------------------------------------------------------
	logic signed [PROD_W-1:0] px0_s4, px1_s4, px2_s4, px3_s4;
	logic signed [PROD_W-1:0] py0_s4, py1_s4, py2_s4, py3_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			px0_s4 <= $signed({1'b0, w0_s3}) * p0_x_q;
			px1_s4 <= $signed({1'b0, w1_s3}) * p1_x_q;
			px2_s4 <= $signed({1'b0, w2_s3}) * p2_x_q;
			px3_s4 <= $signed({1'b0, w3_s3}) * p3_x_q;
			py0_s4 <= $signed({1'b0, w0_s3}) * p0_y_q;
			py1_s4 <= $signed({1'b0, w1_s3}) * p1_y_q;
			py2_s4 <= $signed({1'b0, w2_s3}) * p2_y_q;
			py3_s4 <= $signed({1'b0, w3_s3}) * p3_y_q;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: Bernstein sums
	// ---------------------------------------------------------------
	logic signed [SUM_W-1:0] bx_s5, by_s5;

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			bx_s5 <= px0_s4 + px1_s4 + px2_s4 + px3_s4;
			by_s5 <= py0_s4 + py1_s4 + py2_s4 + py3_s4;
		end
	end

	// ---------------------------------------------------------------
	// Stage 6: split into sign and magnitude for truncation toward zero
	// ---------------------------------------------------------------
	logic [MAG_W-1:0] magx_s6, magy_s6;
	logic             negx_s6, negy_s6;

	always_ff @(posedge clk) begin
		if (en_s6 && vld_s5) begin
			negx_s6 <= bx_s5[SUM_W-1];
			negy_s6 <= by_s5[SUM_W-1];
			magx_s6 <= MAG_W'(bx_s5[SUM_W-1] ? -bx_s5 : bx_s5);
			magy_s6 <= MAG_W'(by_s5[SUM_W-1] ? -by_s5 : by_s5);
		end
	end

	// ---------------------------------------------------------------
	// Stage 7: scale to the screen and drop the STEPS^3 factor
	// ---------------------------------------------------------------
	logic [N_W-1:0] nx_s7, ny_s7;
	logic           negx_s7, negy_s7;

	always_ff @(posedge clk) begin
		if (en_s7 && vld_s6) begin
			nx_s7   <= N_W'((SP_W'(magx_s6) * SP_W'(cbpm_pkg::SCREEN_MAX_X)) >> (3 * SL));
			ny_s7   <= N_W'((SP_W'(magy_s6) * SP_W'(cbpm_pkg::SCREEN_MAX_Y)) >> (3 * SL));
			negx_s7 <= negx_s6;
			negy_s7 <= negy_s6;
		end
	end

	// ---------------------------------------------------------------
	// Stage 8: divide by the user span through its reciprocal
	// ---------------------------------------------------------------
	logic [Q_W-1:0] qx_s8, qy_s8;
	logic           negx_s8, negy_s8;

	always_ff @(posedge clk) begin
		if (en_s8 && vld_s7) begin
			qx_s8   <= Q_W'((QP_W'(nx_s7) * QP_W'(RECIP)) >> RSH);
			qy_s8   <= Q_W'((QP_W'(ny_s7) * QP_W'(RECIP)) >> RSH);
			negx_s8 <= negx_s7;
			negy_s8 <= negy_s7;
		end
	end

	// ---------------------------------------------------------------
	// Stage 9: restore sign, flip y, check bounds, saturate
	// ---------------------------------------------------------------
	logic signed [V_W-1:0]   xv, ty, yv;
	logic signed [PIX_W-1:0] pixel_x_s9, pixel_y_s9;
	logic                    on_screen_s9;

	assign xv = negx_s8 ? -$signed({2'b00, qx_s8}) : $signed({2'b00, qx_s8});
	assign ty = negy_s8 ? -$signed({2'b00, qy_s8}) : $signed({2'b00, qy_s8});
	assign yv = MAX_Y_V - ty;

	always_ff @(posedge clk) begin
		if (en_s9 && vld_s8) begin
			pixel_x_s9   <= sat_pix(xv);
			pixel_y_s9   <= sat_pix(yv);
			on_screen_s9 <= (xv >= 0) && (xv <= MAX_X_V) && (yv >= 0) && (yv <= MAX_Y_V);
		end
	end

	assign pixel_x   = pixel_x_s9;
	assign pixel_y   = pixel_y_s9;
	assign on_screen = on_screen_s9;

`ifndef SYNTHESIS
	// Input stalls only when every stage is full and the output is blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		step_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && vld_s7
			&& vld_s8 && vld_s9 && point_stall))
		else $error("step_stall raised with room in the pipeline");

	// An accepted item lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(step_valid && !step_stall) |=> vld_s1)
		else $error("accepted item lost at stage 1");

	// Clamped index and its complement add up to STEPS
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ((i_s1 <= IDX_W'(cbpm_pkg::STEPS))
			&& ((IDX_W + 1)'(i_s1) + (IDX_W + 1)'(u_s1) == (IDX_W + 1)'(cbpm_pkg::STEPS))))
		else $error("step index clamp broken");

	// Bernstein weights form a partition of STEPS^3
	a_weights: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (CUBE_W'(w0_s3) + CUBE_W'(w1_s3) + CUBE_W'(w2_s3) + CUBE_W'(w3_s3)
			== (CUBE_W'(1) << (3 * SL))))
		else $error("Bernstein weights do not sum to STEPS^3");

	// A point flagged on screen lies within the screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && on_screen) |-> ((pixel_x >= 0) && (pixel_y >= 0)
			&& (pixel_x <= PIX_W'(cbpm_pkg::SCREEN_MAX_X))
			&& (pixel_y <= PIX_W'(cbpm_pkg::SCREEN_MAX_Y))))
		else $error("on_screen set for an off-screen point");
`endif

endmodule

`default_nettype wire

### test/tb_cubic_bezier_point_mapper_unit.sv
// Self-checking testbench for the cubic Bezier point mapper unit.
// Drives step items through a queue, predicts each pixel in place and compares results.
// Depends on cbpm_pkg and rtl/cubic_bezier_point_mapper_unit.sv.
`timescale 1ns / 1ps

module tb_cubic_bezier_point_mapper_unit;

	localparam int PIPE_DEPTH  = 9;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 250000;
	localparam int ROUNDS      = 12;
	localparam int ROUND_ITEMS = 100;

	typedef logic [cbpm_pkg::IDX_W-1:0]   idx_t;
	typedef logic [cbpm_pkg::COORD_W-1:0] coord_t;

	// register indexes outside the map; writes there must be dropped
	localparam logic [cbpm_pkg::CFG_IDX_W-1:0] IDX_UNUSED_LO = 4'd8;
	localparam logic [cbpm_pkg::CFG_IDX_W-1:0] IDX_UNUSED_HI = 4'd15;

	localparam longint PIX_MAX = (longint'(1) <<< (cbpm_pkg::PIX_W - 1)) - 1;
	localparam longint PIX_MIN = -(longint'(1) <<< (cbpm_pkg::PIX_W - 1));

	typedef struct packed {
		logic signed [cbpm_pkg::PIX_W-1:0] x;
		logic signed [cbpm_pkg::PIX_W-1:0] y;
		logic                              vis;
	} point_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [cbpm_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [cbpm_pkg::COORD_W-1:0]      cfg_data = '0;
	logic                              step_valid = 1'b0;
	logic                              step_stall;
	logic [cbpm_pkg::IDX_W-1:0]        step_index = '0;
	logic                              point_valid;
	logic                              point_stall = 1'b0;
	logic signed [cbpm_pkg::PIX_W-1:0] pixel_x;
	logic signed [cbpm_pkg::PIX_W-1:0] pixel_y;
	logic                              on_screen;

	logic [cbpm_pkg::IDX_W-1:0]          pending_steps[$];
	point_t                              expected_points[$];
	logic signed [cbpm_pkg::COORD_W-1:0] ctrl_pt [0:7];

	logic step_fired = 1'b0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_seq = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   mismatches = 0;
	int   cycles = 0;

	cubic_bezier_point_mapper_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.step_valid  (step_valid),
		.step_stall  (step_stall),
		.step_index  (step_index),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.on_screen   (on_screen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bernstein sum scaled by STEPS^3 over one axis starting at register base
	function automatic longint bern_sum(longint i, int base);
		longint u;
		begin
			u = longint'(cbpm_pkg::STEPS) - i;
			return u * u * u * longint'(ctrl_pt[base])
			     + 3 * u * u * i * longint'(ctrl_pt[base + 1])
			     + 3 * u * i * i * longint'(ctrl_pt[base + 2])
			     + i * i * i * longint'(ctrl_pt[base + 3]);
		end
	endfunction

	function automatic logic signed [cbpm_pkg::PIX_W-1:0] clip_pix(longint v);
		begin
			if (v > PIX_MAX)
				v = PIX_MAX;
			if (v < PIX_MIN)
				v = PIX_MIN;
			return v[cbpm_pkg::PIX_W-1:0];
		end
	endfunction

	// Evaluate the curve at one step index and map it to screen space
	function automatic point_t map_point(logic [cbpm_pkg::IDX_W-1:0] idx);
		longint i, span, x, y;
		point_t p;
		begin
			i = (idx > cbpm_pkg::STEPS) ? longint'(cbpm_pkg::STEPS) : longint'(idx);
			span = longint'(cbpm_pkg::USER_SPAN) * cbpm_pkg::STEPS * cbpm_pkg::STEPS
				* cbpm_pkg::STEPS;
			// signed division truncates toward zero
			x = (bern_sum(i, int'(cbpm_pkg::REG_P0_X)) * cbpm_pkg::SCREEN_MAX_X) / span;
			y = cbpm_pkg::SCREEN_MAX_Y
				- (bern_sum(i, int'(cbpm_pkg::REG_P0_Y)) * cbpm_pkg::SCREEN_MAX_Y) / span;
			p.x = clip_pix(x);
			p.y = clip_pix(y);
			p.vis = (x >= 0) && (x <= cbpm_pkg::SCREEN_MAX_X) && (y >= 0)
				&& (y <= cbpm_pkg::SCREEN_MAX_Y);
			return p;
		end
	endfunction

	// Drive step items: hold a stalled item, otherwise offer the next or go idle
	always @(negedge clk) begin
		if (arst_n && (!step_valid || step_fired)) begin
			if (pending_steps.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				step_index <= pending_steps.pop_front();
				step_valid <= 1'b1;
			end else begin
				step_valid <= 1'b0;
			end
		end
	end

	// Drive point_stall: a requested long hold-off, else random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			point_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES - 1;
			point_stall <= 1'b1;
		end else begin
			point_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Check each accepted point, then record the prediction for each accepted step
	always @(posedge clk) begin
		point_t want;
		if (arst_n) begin
			if (point_valid && !point_stall) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected point x=%0d y=%0d on_screen=%0b",
						$time, pixel_x, pixel_y, on_screen);
					mismatches++;
				end else begin
					want = expected_points.pop_front();
					if (pixel_x !== want.x) begin
						$display("%0t: pixel_x expected %0d got %0d", $time, want.x, pixel_x);
						mismatches++;
					end
					if (pixel_y !== want.y) begin
						$display("%0t: pixel_y expected %0d got %0d", $time, want.y, pixel_y);
						mismatches++;
					end
					if (on_screen !== want.vis) begin
						$display("%0t: on_screen expected %0b got %0b",
							$time, want.vis, on_screen);
						mismatches++;
					end
				end
			end
			if (step_valid && !step_stall)
				expected_points.push_back(map_point(step_index));
			step_fired <= step_valid && !step_stall;
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_reg(logic [cbpm_pkg::CFG_IDX_W-1:0] idx,
			logic [cbpm_pkg::COORD_W-1:0] val);
		begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			if (idx <= cbpm_pkg::REG_P3_Y)
				ctrl_pt[idx[2:0]] = val;
		end
	endtask

	task automatic write_curve(coord_t x0, coord_t x1, coord_t x2, coord_t x3,
			coord_t y0, coord_t y1, coord_t y2, coord_t y3);
		begin
			write_reg(cbpm_pkg::REG_P0_X, x0);
			write_reg(cbpm_pkg::REG_P1_X, x1);
			write_reg(cbpm_pkg::REG_P2_X, x2);
			write_reg(cbpm_pkg::REG_P3_X, x3);
			write_reg(cbpm_pkg::REG_P0_Y, y0);
			write_reg(cbpm_pkg::REG_P1_Y, y1);
			write_reg(cbpm_pkg::REG_P2_Y, y2);
			write_reg(cbpm_pkg::REG_P3_Y, y3);
			@(negedge clk);
			cfg_we <= 1'b0;
		end
	endtask

	// Mostly random coordinates, with the extremes now and then
	function automatic coord_t pick_coord();
		begin
			case ($urandom_range(0, 9))
				0: return 11'sd1023;
				1: return -11'sd1024;
				default: return coord_t'($urandom_range(0, 2047));
			endcase
		end
	endfunction

	// Wait until every offered item has been accepted and answered
	task automatic drain();
		begin
			while (pending_steps.size() != 0 || step_valid || expected_points.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic offer(idx_t idx);
		begin
			pending_steps.push_back(idx);
		end
	endtask

	initial begin
		for (int k = 0; k < 8; k++)
			ctrl_pt[k] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset control points: every index maps to the screen's bottom-left corner
		offer(0);
		offer(idx_t'(cbpm_pkg::STEPS));
		offer(2047);
		drain();

		// alternating extremes; the clamp region above STEPS lands on the end point
		write_curve(-11'sd1024, 11'sd1023, -11'sd1024, 11'sd1023,
			11'sd1023, -11'sd1024, 11'sd1023, -11'sd1024);
		offer(0);
		offer(1);
		offer(2);
		offer(511);
		offer(512);
		offer(513);
		offer(1023);
		offer(idx_t'(cbpm_pkg::STEPS));
		offer(idx_t'(cbpm_pkg::STEPS + 1));
		offer(1535);
		offer(2047);
		drain();

		// all at the positive extreme: far off screen right and above
		write_curve(11'sd1023, 11'sd1023, 11'sd1023, 11'sd1023,
			11'sd1023, 11'sd1023, 11'sd1023, 11'sd1023);
		offer(0);
		offer(512);
		offer(idx_t'(cbpm_pkg::STEPS));
		drain();

		// all at the negative extreme: negative truncation and off screen
		write_curve(-11'sd1024, -11'sd1024, -11'sd1024, -11'sd1024,
			-11'sd1024, -11'sd1024, -11'sd1024, -11'sd1024);
		offer(0);
		offer(700);
		offer(idx_t'(cbpm_pkg::STEPS));
		drain();

		// writes above the register map must leave the curve untouched
		write_curve(11'sd1, 11'sd2, 11'sd5, 11'sd6, 11'sd0, 11'sd6, 11'sd3, 11'sd1);
		write_reg(IDX_UNUSED_LO, coord_t'($urandom_range(0, 2047)));
		write_reg(IDX_UNUSED_HI, coord_t'($urandom_range(0, 2047)));
		@(negedge clk);
		cfg_we <= 1'b0;
		offer(300);
		offer(idx_t'(cbpm_pkg::STEPS));
		drain();

		// random rounds, each with a fresh curve and its own idling pattern
		for (int r = 0; r < ROUNDS; r++) begin
			if (r == ROUNDS - 1)
				write_curve(-11'sd1024, -11'sd1024, 11'sd1023, 11'sd1023,
					11'sd1023, 11'sd1023, -11'sd1024, -11'sd1024);
			else
				write_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
					pick_coord(), pick_coord(), pick_coord(), pick_coord());
			case (r % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			for (int n = 0; n < ROUND_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 85)
					offer(idx_t'($urandom_range(0, cbpm_pkg::STEPS)));
				else
					offer(idx_t'($urandom_range(cbpm_pkg::STEPS + 1, 2047)));
			end
			// fill the pipeline against a long receiver hold-off
			if (r == 4) begin
				send_idle_pct = 0;
				hold_seq++;
			end
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (mismatches == 0 && expected_points.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### cubic_bezier_point_mapper_unit.f
rtl/cbpm_pkg.sv
rtl/cubic_bezier_point_mapper_unit.sv
test/tb_cubic_bezier_point_mapper_unit.sv
